// ----- hdl/swf_pkg.sv -----
package swf_pkg;

  localparam int TIME_W     = 48;
  localparam int ELEM_W     = 16;
  localparam int IN_LANES   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W     = 5;
  localparam int STRIDE_W   = 16;
  localparam int DIMS_W     = 3;
  localparam int MINW_W     = 16;
  localparam int SEEN_W     = 2;

  localparam logic [TIME_W-1:0] DEFAULT_STEP = 48'd1000;
  localparam logic [SEEN_W-1:0] SEEN_MAX     = 2'd2;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_PAD     = 1'b1;
  localparam logic STAT_ELEM   = 1'b0;
  localparam logic STAT_DONE   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE     = 3'd0,
    REG_WINDOW_STRIDE   = 3'd1,
    REG_ITEM_DIMS       = 3'd2,
    REG_MINIMUM_WINDOWS = 3'd3,
    REG_PAD_WITH_LAST   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PAD,
    ST_EMIT,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/swf_cell.sv -----
module swf_cell #(
  parameter int DIMS = 4,
  parameter int BITS = 16
) (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [DIMS-1:0][BITS-1:0] d,
  output logic [DIMS-1:0][BITS-1:0] q
);

  logic [DIMS-1:0][BITS-1:0] vec_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      vec_r <= d;
    end
  end

  assign q = vec_r;

endmodule

// ----- hdl/strided_window_framer.sv -----
// Sample transfer: ST_CHECK decides on a window in the cycle after acceptance; ST_EMIT
// registers one element per cycle (size * item_dims elements) while out_tready is high.
// The next transfer is taken in ST_IDLE, entered when the last element is registered or
// after ST_CHECK for a sample that completes no window. Pad vectors go ST_PAD, ST_CHECK.
// Reset (rst_n low, synchronous) clears control, counters and timestamps and loads the
// configuration defaults; the cell contents stay undefined until written.
module strided_window_framer #(
  parameter int MAX_WINDOW = 16,
  parameter int MAX_DIMS   = 4,
  parameter int VALUE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // lane_value_0, lane_value_1, lane_value_2, lane_value_3, sample_time
  input  logic [111:0]                        in_tdata,
  // command
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // element_value, window_time
  output logic [63:0]                         out_tdata,
  output logic                                out_tlast,
  // status
  output logic [0:0]                          out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SZW = (CW > swf_pkg::SIZE_W) ? CW : swf_pkg::SIZE_W;
  localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int LW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int TW  = swf_pkg::TIME_W;
  localparam int EW  = swf_pkg::ELEM_W;

  typedef logic [MAX_DIMS-1:0][VALUE_BITS-1:0] vec_t;

  swf_pkg::state_t state_r, state_nxt;

  logic [swf_pkg::SIZE_W-1:0]   cfg_size_r;
  logic [swf_pkg::STRIDE_W-1:0] cfg_stride_r;
  logic [swf_pkg::DIMS_W-1:0]   cfg_dims_r;
  logic [swf_pkg::MINW_W-1:0]   cfg_minw_r;
  logic                         cfg_padlast_r;

  logic [CW-1:0]                fill_r, fill_nxt;
  logic [swf_pkg::STRIDE_W-1:0] phase_r, phase_nxt;
  logic [swf_pkg::MINW_W-1:0]   emitted_r, emitted_nxt;
  logic [TW-1:0]                last_ts_r, last_ts_nxt;
  logic [TW-1:0]                prev_ts_r, prev_ts_nxt;
  logic [swf_pkg::SEEN_W-1:0]   seen_r, seen_nxt;
  logic [CW-1:0]                vcnt_r, vcnt_nxt;
  logic [LW-1:0]                lane_r, lane_nxt;
  logic                         pad_mode_r, pad_mode_nxt;

  vec_t                         pad_vec_r, pad_vec_nxt;
  logic [TW-1:0]                step_r, step_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [EW-1:0]                out_val_r, out_val_nxt;
  logic [TW-1:0]                out_time_r, out_time_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_stat_r, out_stat_nxt;

  logic [CW-1:0]                ws, ws_m1;
  logic [SZW-1:0]               size_ext;
  logic [swf_pkg::STRIDE_W-1:0] stride_eff;
  logic [DCW-1:0]               dims;
  logic [LW-1:0]                dims_m1;

  vec_t                         in_vec, push_vec, oldest, newest;
  logic [TW-1:0]                in_time, push_time;
  logic                         in_xfer, push, rotate, out_ld, was_full, last_elem;
  logic [swf_pkg::STRIDE_W:0]   phase_inc;
  logic [VALUE_BITS+EW-1:0]     elem_ext;

  vec_t                         cell_d [MAX_WINDOW];
  vec_t                         cell_q [MAX_WINDOW];

  // effective register values
  assign size_ext = SZW'(cfg_size_r);

  always_comb begin
    if (cfg_size_r == '0) begin
      ws = CW'(1);
    end else if (size_ext > SZW'(MAX_WINDOW)) begin
      ws = CW'(MAX_WINDOW);
    end else begin
      ws = CW'(size_ext);
    end
  end

  always_comb begin
    if (cfg_dims_r == '0) begin
      dims = DCW'(1);
    end else if (cfg_dims_r > swf_pkg::DIMS_W'(MAX_DIMS)) begin
      dims = DCW'(MAX_DIMS);
    end else begin
      dims = DCW'(cfg_dims_r);
    end
  end

  assign ws_m1      = ws - CW'(1);
  assign dims_m1    = LW'(dims - DCW'(1));
  assign stride_eff = (cfg_stride_r == '0) ? swf_pkg::STRIDE_W'(1) : cfg_stride_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r    <= swf_pkg::SIZE_W'(1);
      cfg_stride_r  <= swf_pkg::STRIDE_W'(1);
      cfg_dims_r    <= swf_pkg::DIMS_W'(1);
      cfg_minw_r    <= '0;
      cfg_padlast_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swf_pkg::REG_WINDOW_SIZE:     cfg_size_r    <= cfg_data[swf_pkg::SIZE_W-1:0];
        swf_pkg::REG_WINDOW_STRIDE:   cfg_stride_r  <= cfg_data[swf_pkg::STRIDE_W-1:0];
        swf_pkg::REG_ITEM_DIMS:       cfg_dims_r    <= cfg_data[swf_pkg::DIMS_W-1:0];
        swf_pkg::REG_MINIMUM_WINDOWS: cfg_minw_r    <= cfg_data[swf_pkg::MINW_W-1:0];
        swf_pkg::REG_PAD_WITH_LAST:   cfg_padlast_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input unpacking
  assign in_time = in_tdata[swf_pkg::IN_LANES*EW +: TW];

  always_comb begin
    logic [VALUE_BITS+EW-1:0] lane_ext;
    lane_ext = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      lane_ext  = {{VALUE_BITS{1'b0}}, in_tdata[d*EW +: EW]};
      in_vec[d] = lane_ext[VALUE_BITS-1:0];
    end
  end

  // row of cells, newest at cell 0
  assign oldest   = cell_q[ws_m1[IW-1:0]];
  assign newest   = cell_q[0];
  assign push_vec = (state_r == swf_pkg::ST_PAD) ? pad_vec_r : in_vec;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_row
    if (i == 0) begin : g_head
      assign cell_d[i] = rotate ? oldest : push_vec;
    end else begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end
    swf_cell #(
      .DIMS (MAX_DIMS),
      .BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (push | rotate),
      .d        (cell_d[i]),
      .q        (cell_q[i])
    );
  end

  assign in_xfer   = in_tvalid & in_tready;
  assign in_tready = (state_r == swf_pkg::ST_IDLE);
  assign out_ld    = !out_valid_r || out_tready;
  assign was_full  = (fill_r >= ws);
  assign phase_inc = {1'b0, phase_r} + (swf_pkg::STRIDE_W+1)'(1);
  assign push_time = (state_r == swf_pkg::ST_PAD) ? (last_ts_r + step_r) : in_time;
  assign last_elem = (vcnt_r == ws_m1) && (lane_r == dims_m1);
  assign elem_ext  = {{EW{1'b0}}, oldest[lane_r]};

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    phase_nxt     = phase_r;
    emitted_nxt   = emitted_r;
    last_ts_nxt   = last_ts_r;
    prev_ts_nxt   = prev_ts_r;
    seen_nxt      = seen_r;
    vcnt_nxt      = vcnt_r;
    lane_nxt      = lane_r;
    pad_mode_nxt  = pad_mode_r;
    pad_vec_nxt   = pad_vec_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_time_nxt  = out_time_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    push          = 1'b0;
    rotate        = 1'b0;

    unique case (state_r)
      swf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser[0] == swf_pkg::CMD_SAMPLE) begin
            push      = 1'b1;
            state_nxt = swf_pkg::ST_CHECK;
          end else if (seen_r == '0 || emitted_r >= cfg_minw_r) begin
            state_nxt = swf_pkg::ST_DONE;
          end else begin
            for (int d = 0; d < MAX_DIMS; d++) begin
              pad_vec_nxt[d] = (cfg_padlast_r && fill_r != '0 && DCW'(d) < dims) ?
                               newest[d] : '0;
            end
            step_nxt     = (seen_r >= swf_pkg::SEEN_MAX) ? (last_ts_r - prev_ts_r) :
                           swf_pkg::DEFAULT_STEP;
            pad_mode_nxt = 1'b1;
            state_nxt    = swf_pkg::ST_PAD;
          end
        end
      end
      swf_pkg::ST_PAD: begin
        push      = 1'b1;
        state_nxt = swf_pkg::ST_CHECK;
      end
      swf_pkg::ST_CHECK: begin
        vcnt_nxt = '0;
        lane_nxt = '0;
        if (fill_r == ws && phase_r == '0) begin
          state_nxt = swf_pkg::ST_EMIT;
        end else if (pad_mode_r) begin
          state_nxt = swf_pkg::ST_PAD;
        end else begin
          state_nxt = swf_pkg::ST_IDLE;
        end
      end
      swf_pkg::ST_EMIT: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = elem_ext[EW-1:0];
          out_time_nxt  = last_ts_r;
          out_last_nxt  = last_elem;
          out_stat_nxt  = swf_pkg::STAT_ELEM;
          if (lane_r == dims_m1) begin
            rotate   = 1'b1;
            lane_nxt = '0;
            vcnt_nxt = vcnt_r + CW'(1);
          end else begin
            lane_nxt = lane_r + LW'(1);
          end
          if (last_elem) begin
            if (emitted_r != '1) begin
              emitted_nxt = emitted_r + swf_pkg::MINW_W'(1);
            end
            pad_mode_nxt = 1'b0;
            state_nxt    = swf_pkg::ST_IDLE;
          end
        end
      end
      swf_pkg::ST_DONE: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_time_nxt  = (seen_r == '0) ? '0 : last_ts_r;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = swf_pkg::STAT_DONE;
          state_nxt     = swf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swf_pkg::ST_IDLE;
    endcase

    if (push) begin
      fill_nxt = was_full ? ws : fill_r + CW'(1);
      if (!was_full || phase_inc >= {1'b0, stride_eff}) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_inc[swf_pkg::STRIDE_W-1:0];
      end
      prev_ts_nxt = last_ts_r;
      last_ts_nxt = push_time;
      if (seen_r < swf_pkg::SEEN_MAX) begin
        seen_nxt = seen_r + swf_pkg::SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swf_pkg::ST_IDLE;
      fill_r      <= '0;
      phase_r     <= '0;
      emitted_r   <= '0;
      last_ts_r   <= '0;
      prev_ts_r   <= '0;
      seen_r      <= '0;
      vcnt_r      <= '0;
      lane_r      <= '0;
      pad_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      emitted_r   <= emitted_nxt;
      last_ts_r   <= last_ts_nxt;
      prev_ts_r   <= prev_ts_nxt;
      seen_r      <= seen_nxt;
      vcnt_r      <= vcnt_nxt;
      lane_r      <= lane_nxt;
      pad_mode_r  <= pad_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_vec_r  <= pad_vec_nxt;
    step_r     <= step_nxt;
    out_val_r  <= out_val_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_time_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == swf_pkg::STAT_DONE) |-> out_tlast)
    else $error("done status transfer without tlast");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_WINDOW))
    else $error("fill count beyond row length");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == swf_pkg::ST_CHECK || state_r == swf_pkg::ST_PAD ||
                 state_r == swf_pkg::ST_DONE))
    else $error("accepted input left controller idle");

endmodule
